// ----- design/ook_sensor_frame_transmitter_macros.svh -----
// ----------------------------------------------------------------------------
// OOK sensor frame transmitter assertion macros
// Shared property forms used by the transmitter's checks.
// ----------------------------------------------------------------------------
`ifndef OOK_SENSOR_FRAME_TRANSMITTER_MACROS_SVH
`define OOK_SENSOR_FRAME_TRANSMITTER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OOKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define OOKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ookt_pkg.sv -----
// ----------------------------------------------------------------------------
// OOK transmitter package
// Types, register map and reset values shared by the transmitter modules.
// ----------------------------------------------------------------------------
package ookt_pkg;

  localparam int unsigned FRAME_W    = 36;
  localparam int unsigned BITPOS_W   = 6;
  localparam int unsigned TICK_W     = 13;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned REPEAT_W   = 4;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned HUM_W      = 8;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Position after the last frame bit: the trailing zero bit.
  localparam logic [BITPOS_W-1:0] BITPOS_TRAIL = BITPOS_W'(FRAME_W);

  localparam logic [ID_W-1:0]     SENSOR_ID_RST  = 8'd0;
  localparam logic [CHAN_W-1:0]   CHANNEL_RST    = 2'd0;
  localparam logic [TICK_W-1:0]   HIGH_PULSE_RST = 13'd500;
  localparam logic [TICK_W-1:0]   ONE_GAP_RST    = 13'd1800;
  localparam logic [TICK_W-1:0]   ZERO_GAP_RST   = 13'd800;
  localparam logic [TICK_W-1:0]   SYNC_GAP_RST   = 13'd4000;
  localparam logic [REPEAT_W-1:0] REPEAT_RST     = 4'd13;

  // Fixed ones nibble between temperature and humidity.
  localparam logic [3:0] FRAME_MARK = 4'hF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SENSOR_ID      = 3'd0,
    REG_CHANNEL_NUMBER = 3'd1,
    REG_HIGH_PULSE     = 3'd2,
    REG_ONE_GAP        = 3'd3,
    REG_ZERO_GAP       = 3'd4,
    REG_SYNC_GAP       = 3'd5,
    REG_REPEAT_COUNT   = 3'd6
  } ookt_reg_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SEND = 1'b1
  } ookt_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SYNC  = 2'd1,
    PH_PULSE = 2'd2,
    PH_GAP   = 2'd3
  } ookt_phase_e;

  typedef struct packed {
    logic [ID_W-1:0]     sensor_id;
    logic [CHAN_W-1:0]   channel_number;
    logic [TICK_W-1:0]   high_pulse_ticks;
    logic [TICK_W-1:0]   one_gap_ticks;
    logic [TICK_W-1:0]   zero_gap_ticks;
    logic [TICK_W-1:0]   sync_gap_ticks;
    logic [REPEAT_W-1:0] repeat_count;
  } ookt_cfg_t;

  typedef struct packed {
    logic                     mode;
    logic signed [TEMP_W-1:0] temperature_tenths;
    logic [HUM_W-1:0]         humidity_percent;
    logic                     battery_flag;
  } ookt_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
  } ookt_res_t;

  typedef struct packed {
    ookt_phase_e         phase;
    logic [BITPOS_W-1:0] bit_pos;
    logic [REPEAT_W-1:0] repeats_left;
  } ookt_status_t;

endpackage

// ----- design/ookt_if.sv -----
// ----------------------------------------------------------------------------
// OOK transmitter channel interfaces
// Valid/ready channels for send/tick requests and line results.
// ----------------------------------------------------------------------------
interface ookt_in_if import ookt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic [HUM_W-1:0]         humidity_percent;
  logic                     battery_flag;

  modport source (
    output valid, mode, temperature_tenths, humidity_percent, battery_flag,
    input  ready
  );
  modport sink (
    input  valid, mode, temperature_tenths, humidity_percent, battery_flag,
    output ready
  );
endinterface

interface ookt_out_if ();
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;

  modport source (
    output valid, line_level, busy_res,
    input  ready
  );
  modport sink (
    input  valid, line_level, busy_res,
    output ready
  );
endinterface

// ----- design/ookt_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// OOK transmitter configuration registers
// APB register bank for sensor id, channel, timing and repeat count.
// ----------------------------------------------------------------------------
module ookt_cfg_regs import ookt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output ookt_cfg_t             cfg_o
);

  ookt_cfg_t cfg_q;
  ookt_reg_e reg_idx;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = ookt_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_id        <= SENSOR_ID_RST;
      cfg_q.channel_number   <= CHANNEL_RST;
      cfg_q.high_pulse_ticks <= HIGH_PULSE_RST;
      cfg_q.one_gap_ticks    <= ONE_GAP_RST;
      cfg_q.zero_gap_ticks   <= ZERO_GAP_RST;
      cfg_q.sync_gap_ticks   <= SYNC_GAP_RST;
      cfg_q.repeat_count     <= REPEAT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SENSOR_ID:      cfg_q.sensor_id        <= pwdata[ID_W-1:0];
        REG_CHANNEL_NUMBER: cfg_q.channel_number   <= pwdata[CHAN_W-1:0];
        REG_HIGH_PULSE:     cfg_q.high_pulse_ticks <= pwdata[TICK_W-1:0];
        REG_ONE_GAP:        cfg_q.one_gap_ticks    <= pwdata[TICK_W-1:0];
        REG_ZERO_GAP:       cfg_q.zero_gap_ticks   <= pwdata[TICK_W-1:0];
        REG_SYNC_GAP:       cfg_q.sync_gap_ticks   <= pwdata[TICK_W-1:0];
        REG_REPEAT_COUNT:   cfg_q.repeat_count     <= pwdata[REPEAT_W-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENSOR_ID:      prdata = APB_DATA_W'(cfg_q.sensor_id);
      REG_CHANNEL_NUMBER: prdata = APB_DATA_W'(cfg_q.channel_number);
      REG_HIGH_PULSE:     prdata = APB_DATA_W'(cfg_q.high_pulse_ticks);
      REG_ONE_GAP:        prdata = APB_DATA_W'(cfg_q.one_gap_ticks);
      REG_ZERO_GAP:       prdata = APB_DATA_W'(cfg_q.zero_gap_ticks);
      REG_SYNC_GAP:       prdata = APB_DATA_W'(cfg_q.sync_gap_ticks);
      REG_REPEAT_COUNT:   prdata = APB_DATA_W'(cfg_q.repeat_count);
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- design/ookt_engine.sv -----
// ----------------------------------------------------------------------------
// OOK transmitter burst engine
// Phase sequencer for sync gap, bit pulses and gaps; one request per cycle.
// ----------------------------------------------------------------------------
module ookt_engine import ookt_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  ookt_item_t   item_i,
  input  ookt_cfg_t    cfg_i,
  output ookt_res_t    res_o,
  output ookt_status_t status_o
);

  localparam int unsigned LenW = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;

  ookt_phase_e             phase_q, phase_d, view_phase;
  logic [TIMER_WIDTH-1:0]  timer_q, timer_d;
  logic [BITPOS_W-1:0]     bit_pos_q, bit_pos_d, bit_idx;
  logic [REPEAT_W-1:0]     reps_q, reps_d, reps_dec;
  logic [FRAME_W-1:0]      frame_q, frame_d;
  logic                    cur_bit;
  logic [TICK_W-1:0]       raw_len;
  logic [LenW-1:0]         raw_ext, tmax_ext, len;
  logic [LenW:0]           timer_inc;
  logic                    phase_done;
  logic                    is_send;

  assign is_send = (item_i.mode == MODE_SEND);

  // Current frame bit; the trailing bit is always zero.
  assign bit_idx = BITPOS_W'(FRAME_W - 1) - bit_pos_q;
  assign cur_bit = (bit_pos_q < BITPOS_TRAIL) ? frame_q[bit_idx] : 1'b0;

  always_comb begin
    priority if (phase_q == PH_SYNC) begin
      raw_len = cfg_i.sync_gap_ticks;
    end else if (phase_q == PH_PULSE) begin
      raw_len = cfg_i.high_pulse_ticks;
    end else if (cur_bit) begin
      raw_len = cfg_i.one_gap_ticks;
    end else begin
      raw_len = cfg_i.zero_gap_ticks;
    end
  end

  // Clamp the phase length to [1, timer max].
  assign raw_ext   = LenW'(raw_len);
  assign tmax_ext  = LenW'({TIMER_WIDTH{1'b1}});
  assign len       = (raw_len == '0) ? LenW'(1)
                   : ((raw_ext > tmax_ext) ? tmax_ext : raw_ext);
  assign timer_inc = (LenW+1)'(timer_q) + (LenW+1)'(1);
  assign phase_done = (timer_inc >= {1'b0, len});
  assign reps_dec  = reps_q - REPEAT_W'(1);

  // Next state
  always_comb begin
    phase_d   = phase_q;
    timer_d   = timer_q;
    bit_pos_d = bit_pos_q;
    reps_d    = reps_q;
    frame_d   = frame_q;
    if (fire_i) begin
      if (is_send) begin
        // A send while busy or with zero repeats is dropped.
        if (phase_q == PH_IDLE && cfg_i.repeat_count != '0) begin
          frame_d = {cfg_i.sensor_id, item_i.battery_flag, 1'b0,
                     cfg_i.channel_number, item_i.temperature_tenths,
                     FRAME_MARK, item_i.humidity_percent};
          bit_pos_d = '0;
          reps_d    = cfg_i.repeat_count;
          phase_d   = PH_SYNC;
          timer_d   = '0;
        end
      end else if (phase_q != PH_IDLE) begin
        if (phase_done) begin
          timer_d = '0;
          unique case (phase_q)
            PH_SYNC:  phase_d = PH_PULSE;
            PH_PULSE: phase_d = PH_GAP;
            PH_GAP: begin
              if (bit_pos_q < BITPOS_TRAIL) begin
                bit_pos_d = bit_pos_q + BITPOS_W'(1);
                phase_d   = PH_PULSE;
              end else begin
                reps_d    = reps_dec;
                bit_pos_d = '0;
                phase_d   = (reps_dec == '0) ? PH_IDLE : PH_SYNC;
              end
            end
            PH_IDLE:  phase_d = PH_IDLE;
          endcase
        end else begin
          timer_d = timer_q + TIMER_WIDTH'(1);
        end
      end
    end
  end

  // Outputs: a tick reports the microsecond just spent, a send the new state.
  always_comb begin
    view_phase       = is_send ? phase_d : phase_q;
    res_o.line_level = (view_phase == PH_PULSE);
    res_o.busy_res   = (view_phase != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      timer_q   <= '0;
      bit_pos_q <= '0;
      reps_q    <= '0;
      frame_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      bit_pos_q <= bit_pos_d;
      reps_q    <= reps_d;
      frame_q   <= frame_d;
    end
  end

  assign status_o.phase        = phase_q;
  assign status_o.bit_pos      = bit_pos_q;
  assign status_o.repeats_left = reps_q;

endmodule

// ----- design/ookt_out_reg.sv -----
// ----------------------------------------------------------------------------
// OOK transmitter result register
// Holds one result until the receiver takes it; frees in the same cycle.
// ----------------------------------------------------------------------------
module ookt_out_reg import ookt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  ookt_res_t  res_i,
  output logic       take_o,
  ookt_out_if.source res_o
);

  logic      valid_q;
  ookt_res_t data_q;

  // Accept a new result when empty or when the held one leaves this cycle.
  assign take_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.line_level = data_q.line_level;
  assign res_o.busy_res   = data_q.busy_res;

endmodule

// ----- design/ook_sensor_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// OOK sensor frame transmitter
// Pulse-distance transmitter for a 36-bit weather-sensor frame.
//
// Requests arrive on req_i: mode 0 is one microsecond tick, mode 1 a send
// that builds the frame from the APB registers and the request's
// temperature, humidity and battery fields and starts a burst of
// repeat_count repetitions. A send while a burst runs is dropped.
// Each request yields one result on res_o: line_level and busy_res for the
// tick just spent, or the state just after a send.
// The result is registered at the edge that accepts the request. One
// request is taken every cycle while the receiver keeps up; the phase timer
// and the sequencer update in the cycle that takes it.
// When the receiver stalls, the held result stays and req_i.ready drops
// until it is taken; ready returns in the cycle the result leaves.
// Reset loads the register defaults and leaves the line idle and low.
// ----------------------------------------------------------------------------
`include "ook_sensor_frame_transmitter_macros.svh"

module ook_sensor_frame_transmitter import ookt_pkg::*; #(
  parameter int unsigned TIMER_WIDTH = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ookt_in_if.sink               req_i,
  ookt_out_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ookt_cfg_t    cfg;
  ookt_item_t   item;
  ookt_res_t    res;
  ookt_status_t st;
  logic         take;
  logic         fire;

  assign req_i.ready = take;
  assign fire        = req_i.valid && take;

  assign item.mode               = req_i.mode;
  assign item.temperature_tenths = req_i.temperature_tenths;
  assign item.humidity_percent   = req_i.humidity_percent;
  assign item.battery_flag       = req_i.battery_flag;

  ookt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ookt_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .cfg_i    (cfg),
    .res_o    (res),
    .status_o (st)
  );

  ookt_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .take_o (take),
    .res_o  (res_o)
  );

  `OOKT_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, fire, res_o.valid, "accepted request left no result")
  `OOKT_ASSERT_IMPL(a_busy_has_repeats, clk_i, rst_ni, st.phase != PH_IDLE, st.repeats_left != '0, "burst running with no repeats left")
  `OOKT_ASSERT_IMPL(a_bit_pos_range, clk_i, rst_ni, 1'b1, st.bit_pos <= BITPOS_TRAIL, "bit position past trailing bit")
  `OOKT_ASSERT_IMPL(a_level_needs_busy, clk_i, rst_ni, res_o.valid && res_o.line_level, res_o.busy_res, "line high while idle")

endmodule

// ----- bench/ook_sensor_frame_transmitter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK sensor frame transmitter testbench
// Drives tick and send requests through the valid/ready channels, programs
// the timing registers over APB between bursts, and checks every line/busy
// result against a cycle-free model of the pulse-distance sequencer.
// ----------------------------------------------------------------------------
module ook_sensor_frame_transmitter_tb;
  import ookt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned REG_UNMAPPED = 7;
  localparam int unsigned MAX_PRINTS   = 100;

  // Tracks the frame sequencer per request and holds the line results due.
  class line_level_tracker;
    ookt_cfg_t           regs;
    logic [FRAME_W-1:0]  frame;
    logic [BITPOS_W-1:0] bit_pos;
    logic [REPEAT_W-1:0] reps_left;
    ookt_phase_e         phase;
    logic [TICK_W-1:0]   ticks_spent;
    ookt_res_t           expected_levels[$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      regs = '{sensor_id: SENSOR_ID_RST, channel_number: CHANNEL_RST,
               high_pulse_ticks: HIGH_PULSE_RST, one_gap_ticks: ONE_GAP_RST,
               zero_gap_ticks: ZERO_GAP_RST, sync_gap_ticks: SYNC_GAP_RST,
               repeat_count: REPEAT_RST};
      frame        = '0;
      bit_pos      = '0;
      reps_left    = '0;
      phase        = PH_IDLE;
      ticks_spent  = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_register(int unsigned idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        REG_SENSOR_ID:      regs.sensor_id        = data[ID_W-1:0];
        REG_CHANNEL_NUMBER: regs.channel_number   = data[CHAN_W-1:0];
        REG_HIGH_PULSE:     regs.high_pulse_ticks = data[TICK_W-1:0];
        REG_ONE_GAP:        regs.one_gap_ticks    = data[TICK_W-1:0];
        REG_ZERO_GAP:       regs.zero_gap_ticks   = data[TICK_W-1:0];
        REG_SYNC_GAP:       regs.sync_gap_ticks   = data[TICK_W-1:0];
        REG_REPEAT_COUNT:   regs.repeat_count     = data[REPEAT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit in_burst();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction

    // A zero length still holds the phase for one tick.
    function logic [TICK_W-1:0] phase_length();
      logic [TICK_W-1:0] len;
      logic              cur_bit;
      cur_bit = (bit_pos < BITPOS_TRAIL) ? frame[FRAME_W - 1 - bit_pos] : 1'b0;
      case (phase)
        PH_SYNC:  len = regs.sync_gap_ticks;
        PH_PULSE: len = regs.high_pulse_ticks;
        default:  len = cur_bit ? regs.one_gap_ticks : regs.zero_gap_ticks;
      endcase
      return (len == '0) ? TICK_W'(1) : len;
    endfunction

    function void next_phase();
      ticks_spent = '0;
      case (phase)
        PH_SYNC:  phase = PH_PULSE;
        PH_PULSE: phase = PH_GAP;
        default: begin
          if (bit_pos < BITPOS_TRAIL) begin
            bit_pos = bit_pos + 1'b1;
            phase   = PH_PULSE;
          end else begin
            reps_left = reps_left - 1'b1;
            bit_pos   = '0;
            phase     = (reps_left == '0) ? PH_IDLE : PH_SYNC;
          end
        end
      endcase
    endfunction

    // Returns 0 when the block drops the request.
    function bit take_request(ookt_item_t it);
      ookt_res_t r;
      bit        acted;
      acted = 1'b1;
      if (it.mode == MODE_SEND) begin
        if (phase == PH_IDLE && regs.repeat_count != '0) begin
          frame = {regs.sensor_id, it.battery_flag, 1'b0, regs.channel_number,
                   it.temperature_tenths, FRAME_MARK, it.humidity_percent};
          bit_pos     = '0;
          reps_left   = regs.repeat_count;
          phase       = PH_SYNC;
          ticks_spent = '0;
        end else begin
          acted = 1'b0;
        end
        r.line_level = (phase == PH_PULSE);
        r.busy_res   = (phase != PH_IDLE);
      end else if (phase == PH_IDLE) begin
        r = '0;
      end else begin
        r.line_level = (phase == PH_PULSE);
        r.busy_res   = 1'b1;
        if (int'(ticks_spent) + 1 >= int'(phase_length()))
          next_phase();
        else
          ticks_spent = ticks_spent + 1'b1;
      end
      expected_levels.push_back(r);
      return acted;
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t: result %0d: %s", $time, results_seen, what);
    endtask

    task compare_level(ookt_res_t got);
      ookt_res_t want;
      results_seen++;
      if (expected_levels.size() == 0) begin
        flag_mismatch("result with no request outstanding");
        return;
      end
      want = expected_levels.pop_front();
      if (got.line_level !== want.line_level)
        flag_mismatch($sformatf("line_level %b, want %b", got.line_level, want.line_level));
      if (got.busy_res !== want.busy_res)
        flag_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ookt_in_if  req_if ();
  ookt_out_if res_if ();

  line_level_tracker sb;
  int unsigned       burst_left = 0;
  int unsigned       acted_items = 0;

  ook_sensor_frame_transmitter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Sender: bursts of requests separated by short random gaps.
  task automatic push_item(ookt_item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    req_if.valid              <= 1'b1;
    req_if.mode               <= it.mode;
    req_if.temperature_tenths <= it.temperature_tenths;
    req_if.humidity_percent   <= it.humidity_percent;
    req_if.battery_flag       <= it.battery_flag;
    do @(posedge clk_i); while (!req_if.ready);
    if (sb.take_request(it))
      acted_items++;
  endtask

  task automatic push_random(ookt_mode_e m);
    ookt_item_t it;
    it      = ookt_item_t'($bits(ookt_item_t)'($urandom));
    it.mode = m;
    push_item(it);
  endtask

  task automatic send_reading(logic signed [TEMP_W-1:0] temp, logic [HUM_W-1:0] hum,
                              logic batt);
    ookt_item_t it;
    it.mode               = MODE_SEND;
    it.temperature_tenths = temp;
    it.humidity_percent   = hum;
    it.battery_flag       = batt;
    push_item(it);
  endtask

  // Tick until the burst ends, dropping in a few sends that must be ignored.
  task automatic finish_burst(int unsigned busy_send_pct);
    while (sb.in_burst()) begin
      if ($urandom_range(0, 99) < busy_send_pct)
        push_random(MODE_SEND);
      else
        push_random(MODE_TICK);
    end
  endtask

  // Hold the request channel until every result due has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic apb_write(int unsigned idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Junk above each field must be masked off by the register file.
  task automatic load_settings(ookt_cfg_t c, bit junk);
    wait_drained();
    apb_write(REG_SENSOR_ID,      32'(c.sensor_id)        | (junk ? $urandom << ID_W : 0));
    apb_write(REG_CHANNEL_NUMBER, 32'(c.channel_number)   | (junk ? $urandom << CHAN_W : 0));
    apb_write(REG_HIGH_PULSE,     32'(c.high_pulse_ticks) | (junk ? $urandom << TICK_W : 0));
    apb_write(REG_ONE_GAP,        32'(c.one_gap_ticks)    | (junk ? $urandom << TICK_W : 0));
    apb_write(REG_ZERO_GAP,       32'(c.zero_gap_ticks)   | (junk ? $urandom << TICK_W : 0));
    apb_write(REG_SYNC_GAP,       32'(c.sync_gap_ticks)   | (junk ? $urandom << TICK_W : 0));
    apb_write(REG_REPEAT_COUNT,   32'(c.repeat_count)     | (junk ? $urandom << REPEAT_W : 0));
  endtask

  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return TICK_W'($urandom_range(3, 6));
      default: return TICK_W'($urandom_range(1, 2));
    endcase
  endfunction

  function automatic logic [REPEAT_W-1:0] pick_repeats();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return REPEAT_W'($urandom_range(2, 3));
      default: return REPEAT_W'(1);
    endcase
  endfunction

  // Receiver: a rotating stall mask, reshuffled whenever its countdown runs out.
  initial begin : receiver
    logic [31:0] rx_mask;
    int unsigned rx_left;
    rx_mask = '1;
    rx_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_left == 0) begin
        rx_left = 512;
        case ($urandom_range(0, 3))
          0: rx_mask = '1;
          1: rx_mask = $urandom | $urandom;
          2: rx_mask = $urandom | 32'h1;
          default: rx_mask = $urandom | 32'h0001_0000;
        endcase
      end
      rx_left--;
      res_if.ready <= rx_mask[0];
      rx_mask = {rx_mask[0], rx_mask[31:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.compare_level('{line_level: res_if.line_level, busy_res: res_if.busy_res});
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[ook_sensor_frame_transmitter] ERROR");
    $finish;
  end

  initial begin : stimulus
    ookt_cfg_t   cfg;
    int unsigned rand_start;
    int unsigned phase_no;
    sb = new();
    rst_ni                    <= 1'b0;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    req_if.valid              <= 1'b0;
    req_if.mode               <= MODE_TICK;
    req_if.temperature_tenths <= '0;
    req_if.humidity_percent   <= '0;
    req_if.battery_flag       <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks, then a send with no repetitions programmed.
    push_random(MODE_TICK);
    push_random(MODE_TICK);
    load_settings('{sensor_id: 8'hA5, channel_number: 2'd2, high_pulse_ticks: 13'd0,
                    one_gap_ticks: 13'd2, zero_gap_ticks: 13'd1, sync_gap_ticks: 13'd0,
                    repeat_count: 4'd0}, 1'b0);
    send_reading(12'sd5, 8'd50, 1'b1);
    push_random(MODE_TICK);
    wait_drained();
    apb_write(REG_UNMAPPED, '1);
    apb_write(REG_REPEAT_COUNT, 32'd1);
    // Field extremes; the second send lands mid-burst and must be dropped.
    send_reading(-12'sd2048, 8'd0, 1'b0);
    send_reading(12'sd2047, 8'd255, 1'b1);
    finish_burst(0);
    send_reading(12'sd2047, 8'd255, 1'b1);
    finish_burst(0);

    rand_start = acted_items;
    phase_no   = 0;
    while (acted_items - rand_start < RANDOM_ITEMS) begin
      cfg.sensor_id        = ID_W'($urandom);
      cfg.channel_number   = CHAN_W'($urandom);
      cfg.high_pulse_ticks = pick_ticks();
      cfg.one_gap_ticks    = pick_ticks();
      cfg.zero_gap_ticks   = pick_ticks();
      cfg.sync_gap_ticks   = pick_ticks();
      cfg.repeat_count     = pick_repeats();
      load_settings(cfg, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0)
        apb_write(REG_UNMAPPED, $urandom);
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 3)) push_random(MODE_TICK);
        push_random(MODE_SEND);
        if (phase_no == 0 || $urandom_range(0, 5) == 0)
          wait_drained();
        finish_burst(5);
      end
      phase_no++;
    end

    // Longer lengths, one at a time, then several repetitions at minimum length.
    load_settings('{sensor_id: 8'h00, channel_number: 2'd0, high_pulse_ticks: 13'd1,
                    one_gap_ticks: 13'd1, zero_gap_ticks: 13'd1, sync_gap_ticks: 13'd24,
                    repeat_count: 4'd1}, 1'b0);
    push_random(MODE_SEND);
    finish_burst(1);
    load_settings('{sensor_id: 8'hFF, channel_number: 2'd3, high_pulse_ticks: 13'd1,
                    one_gap_ticks: 13'd1, zero_gap_ticks: 13'd8, sync_gap_ticks: 13'd1,
                    repeat_count: 4'd1}, 1'b0);
    send_reading(-12'sd1, 8'd255, 1'b1);
    finish_burst(1);
    load_settings('{sensor_id: 8'h00, channel_number: 2'd0, high_pulse_ticks: 13'd1,
                    one_gap_ticks: 13'd8, zero_gap_ticks: 13'd1, sync_gap_ticks: 13'd1,
                    repeat_count: 4'd1}, 1'b0);
    send_reading(12'sd0, 8'd0, 1'b0);
    finish_burst(1);
    load_settings('{sensor_id: 8'h3C, channel_number: 2'd1, high_pulse_ticks: 13'd3,
                    one_gap_ticks: 13'd0, zero_gap_ticks: 13'd0, sync_gap_ticks: 13'd0,
                    repeat_count: 4'd1}, 1'b0);
    push_random(MODE_SEND);
    finish_burst(1);
    load_settings('{sensor_id: 8'hFF, channel_number: 2'd3, high_pulse_ticks: 13'd0,
                    one_gap_ticks: 13'd0, zero_gap_ticks: 13'd0, sync_gap_ticks: 13'd0,
                    repeat_count: 4'd3}, 1'b0);
    push_random(MODE_SEND);
    finish_burst(3);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("[ook_sensor_frame_transmitter] OK");
    else
      $display("[ook_sensor_frame_transmitter] ERROR");
    $finish;
  end

endmodule
